@@ rtl/sorted_record_table_unit_assert.svh @@
// Assertion macros used by the sorted record table checker
`ifndef SORTED_RECORD_TABLE_UNIT_ASSERT_SVH
`define SORTED_RECORD_TABLE_UNIT_ASSERT_SVH

// same-cycle implication, sampled on clk, off while rst_n is low
`define SRT_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication
`define SRT_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

@@ rtl/srt_pkg.sv @@
// Shared types and constants of the sorted record table
package srt_pkg;

  localparam int MODE_W   = 2;
  localparam int POSTAL_W = 20;
  localparam int ID_W     = 47;
  localparam int STATUS_W = 2;
  localparam int POS_W    = 5;
  localparam int COUNT_W  = 6;

  // request word: mode, postal_index, mail_id
  localparam int IN_MODE_LSB   = 0;
  localparam int IN_POSTAL_LSB = IN_MODE_LSB + MODE_W;
  localparam int IN_ID_LSB     = IN_POSTAL_LSB + POSTAL_W;
  localparam int IN_BITS       = IN_ID_LSB + ID_W;
  localparam int IN_W          = ((IN_BITS + 7) / 8) * 8;

  // result word: status, position, found_postal_index, found_sent, entry_count
  localparam int OUT_STATUS_LSB = 0;
  localparam int OUT_POS_LSB    = OUT_STATUS_LSB + STATUS_W;
  localparam int OUT_POSTAL_LSB = OUT_POS_LSB + POS_W;
  localparam int OUT_SENT_LSB   = OUT_POSTAL_LSB + POSTAL_W;
  localparam int OUT_COUNT_LSB  = OUT_SENT_LSB + 1;
  localparam int OUT_BITS       = OUT_COUNT_LSB + COUNT_W;
  localparam int OUT_W          = ((OUT_BITS + 7) / 8) * 8;

  typedef enum logic [MODE_W-1:0] {
    OP_INSERT = 2'd0,
    OP_DELETE = 2'd1,
    OP_LOOKUP = 2'd2,
    OP_MARK   = 2'd3
  } op_t;

  typedef enum logic [STATUS_W-1:0] {
    ST_OK      = 2'd0,
    ST_DUP     = 2'd1,
    ST_MISSING = 2'd2,
    ST_FULL    = 2'd3
  } status_t;

  typedef enum logic {
    S_IDLE  = 1'b0,
    S_APPLY = 1'b1
  } state_t;

  typedef struct packed {
    logic [POSTAL_W-1:0] postal;
    logic [ID_W-1:0]     id;
    logic                sent;
  } entry_t;

  // key broadcast to every cell when a request is taken
  typedef struct packed {
    logic                en;
    logic [POSTAL_W-1:0] postal;
    logic [ID_W-1:0]     id;
  } cmp_t;

  // update broadcast in the apply state, when the result is committed
  typedef struct packed {
    logic                go;
    op_t                 op;
    logic [POSTAL_W-1:0] postal;
    logic [ID_W-1:0]     id;
  } upd_t;

  // per-cell compare results
  typedef struct packed {
    logic match;
    logic high;
    logic ins_here;
  } flags_t;

endpackage

@@ rtl/srt_cell.sv @@
// One slot of the sorted table: holds an entry, compares it and shifts with its neighbors
module srt_cell #(
  parameter int IDX   = 0,
  parameter int CNT_W = 6
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic [CNT_W-1:0]   count,
  input  srt_pkg::cmp_t      cmp,
  input  srt_pkg::upd_t      upd,
  input  logic               del_sel,
  input  logic               high_prev,
  input  srt_pkg::entry_t    left_entry,
  input  srt_pkg::entry_t    right_entry,
  output srt_pkg::entry_t    entry,
  output srt_pkg::flags_t    flags
);
  import srt_pkg::*;

  entry_t entry_r, entry_nxt;
  logic   match_r, match_nxt;
  logic   high_r, high_nxt;
  logic   valid;
  logic   greater;

  assign valid = count > CNT_W'(IDX);

  always_comb begin
    greater = (entry_r.postal != cmp.postal) ? (entry_r.postal > cmp.postal)
                                             : (entry_r.id > cmp.id);
    match_nxt = match_r;
    high_nxt  = high_r;
    if (cmp.en) begin
      match_nxt = valid && (entry_r.id == cmp.id);
      // slots at or past the insertion point; monotonic along the row
      high_nxt  = !valid || greater;
    end
  end

  always_comb begin
    entry_nxt = entry_r;
    if (upd.go) begin
      unique case (upd.op)
        OP_INSERT: begin
          if (high_r && !high_prev) begin
            entry_nxt.postal = upd.postal;
            entry_nxt.id     = upd.id;
            entry_nxt.sent   = 1'b0;
          end else if (high_prev) begin
            entry_nxt = left_entry;
          end
        end
        OP_DELETE: begin
          if (del_sel) entry_nxt = right_entry;
        end
        OP_MARK: begin
          if (match_r) entry_nxt.sent = 1'b1;
        end
        OP_LOOKUP: begin
          entry_nxt = entry_r;
        end
        default: entry_nxt = entry_r;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    entry_r <= entry_nxt;
    if (!rst_n) begin
      match_r <= 1'b0;
      high_r  <= 1'b0;
    end else begin
      match_r <= match_nxt;
      high_r  <= high_nxt;
    end
  end

  assign entry          = entry_r;
  assign flags.match    = match_r;
  assign flags.high     = high_r;
  assign flags.ins_here = high_r && !high_prev;

endmodule

@@ rtl/sorted_record_table_unit.sv @@
// Top level of the sorted record table: request sequencer around a row of slot cells
//
//   channel | dir | payload (lsb first)                                   | handshake
//   in_     | in  | mode, postal_index, mail_id                           | tvalid/tready
//   out_    | out | status, position, found_postal_index, found_sent,     | tvalid/tready
//           |     | entry_count                                           |
//
// A request is taken only in the idle state; the accept edge registers the key compare in
// every cell. In the apply state the commit edge encodes the slot, shifts the row and
// loads the result register. No new request is taken until the last one is committed;
// a result waiting at out_ holds the apply state until it is taken.
// Reset (rst_n low, synchronous) empties the table; it needs no clearing pass.
module sorted_record_table_unit #(
  parameter int TABLE_DEPTH = 32
) (
  input  logic                     clk,
  input  logic                     rst_n,
  input  logic                     in_tvalid,
  output logic                     in_tready,
  // mode[1:0], postal_index[21:2], mail_id[68:22], zero pad
  input  logic [srt_pkg::IN_W-1:0]  in_tdata,
  output logic                     out_tvalid,
  input  logic                     out_tready,
  // status[1:0], position[6:2], found_postal_index[26:7], found_sent[27],
  // entry_count[33:28], zero pad
  output logic [srt_pkg::OUT_W-1:0] out_tdata
);
  import srt_pkg::*;

  localparam int IDX_W = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
  localparam int CNT_W = $clog2(TABLE_DEPTH + 1);

  state_t               state_r, state_nxt;
  logic [CNT_W-1:0]     count_r, count_nxt;
  op_t                  mode_r, mode_nxt;
  logic [POSTAL_W-1:0]  postal_r, postal_nxt;
  logic [ID_W-1:0]      id_r, id_nxt;
  logic                 out_valid_r, out_valid_nxt;
  logic [OUT_W-1:0]     out_data_r, out_data_nxt;

  cmp_t                 cmp;
  upd_t                 upd;
  entry_t               ents [TABLE_DEPTH];
  flags_t               flgs [TABLE_DEPTH];
  logic [TABLE_DEPTH-1:0] match_v, ins_v, del_v;

  logic                 accept, commit, any_match, full;
  logic                 apply_go;
  logic [IDX_W-1:0]     slot, at;
  logic [POSTAL_W-1:0]  hit_postal;
  logic                 hit_sent;
  status_t              status;
  logic [IDX_W-1:0]     pos_idx;
  logic [IDX_W+POS_W-1:0]   pos_ext;
  logic [CNT_W+COUNT_W-1:0] cnt_ext;
  logic [POSTAL_W-1:0]  res_postal;
  logic                 res_sent;

  assign in_tready = (state_r == S_IDLE);
  assign accept    = in_tvalid && in_tready;

  assign cmp.en     = accept;
  assign cmp.postal = in_tdata[IN_POSTAL_LSB +: POSTAL_W];
  assign cmp.id     = in_tdata[IN_ID_LSB +: ID_W];

  for (genvar i = 0; i < TABLE_DEPTH; i++) begin : g_cell
    logic   hp;
    entry_t le, re;
    if (i == 0) begin : g_first
      assign hp = 1'b0;
      assign le = ents[i];
    end else begin : g_mid
      assign hp = flgs[i-1].high;
      assign le = ents[i-1];
    end
    if (i == TABLE_DEPTH - 1) begin : g_last
      assign re = ents[i];
    end else begin : g_body
      assign re = ents[i+1];
    end

    srt_cell #(.IDX(i), .CNT_W(CNT_W)) u_cell (
      .clk         (clk),
      .rst_n       (rst_n),
      .count       (count_r),
      .cmp         (cmp),
      .upd         (upd),
      .del_sel     (del_v[i]),
      .high_prev   (hp),
      .left_entry  (le),
      .right_entry (re),
      .entry       (ents[i]),
      .flags       (flgs[i])
    );

    assign match_v[i] = flgs[i].match;
    assign ins_v[i]   = flgs[i].ins_here;
  end

  // match and insertion edge are one-hot, so an OR encode finds the slot
  always_comb begin
    slot       = '0;
    at         = '0;
    hit_postal = '0;
    hit_sent   = 1'b0;
    for (int i = 0; i < TABLE_DEPTH; i++) begin
      if (match_v[i]) begin
        slot       = slot | IDX_W'(i);
        hit_postal = hit_postal | ents[i].postal;
        hit_sent   = hit_sent | ents[i].sent;
      end
      if (ins_v[i]) at = at | IDX_W'(i);
    end
  end

  assign any_match = |match_v;
  assign full      = (count_r == CNT_W'(TABLE_DEPTH));
  // slots at and above the deleted one pull from the right
  assign del_v     = ~(match_v - TABLE_DEPTH'(1));

  always_comb begin
    status     = ST_OK;
    pos_idx    = '0;
    res_postal = '0;
    res_sent   = 1'b0;
    count_nxt  = count_r;
    apply_go   = 1'b0;
    if (mode_r == OP_INSERT) begin
      if (any_match) begin
        status  = ST_DUP;
        pos_idx = slot;
      end else if (full) begin
        status  = ST_FULL;
      end else begin
        pos_idx   = at;
        count_nxt = count_r + CNT_W'(1);
        apply_go  = 1'b1;
      end
    end else if (!any_match) begin
      status = ST_MISSING;
    end else begin
      pos_idx = slot;
      unique case (mode_r)
        OP_DELETE: begin
          count_nxt = count_r - CNT_W'(1);
          apply_go  = 1'b1;
        end
        OP_LOOKUP: begin
          res_postal = hit_postal;
          res_sent   = hit_sent;
        end
        OP_MARK: begin
          res_sent = 1'b1;
          apply_go = 1'b1;
        end
        default: begin
          apply_go = 1'b0;
        end
      endcase
    end
  end

  assign upd.op     = mode_r;
  assign upd.postal = postal_r;
  assign upd.id     = id_r;
  assign pos_ext    = {{POS_W{1'b0}}, pos_idx};
  assign cnt_ext    = {{COUNT_W{1'b0}}, count_nxt};

  always_comb begin
    state_nxt     = state_r;
    mode_nxt      = mode_r;
    postal_nxt    = postal_r;
    id_nxt        = id_r;
    out_valid_nxt = out_valid_r && !out_tready;
    out_data_nxt  = out_data_r;
    commit        = 1'b0;
    unique case (state_r)
      S_IDLE: begin
        if (accept) begin
          mode_nxt   = op_t'(in_tdata[IN_MODE_LSB +: MODE_W]);
          postal_nxt = cmp.postal;
          id_nxt     = cmp.id;
          state_nxt  = S_APPLY;
        end
      end
      S_APPLY: begin
        if (!out_valid_r || out_tready) begin
          commit        = 1'b1;
          out_valid_nxt = 1'b1;
          out_data_nxt  = '0;
          out_data_nxt[OUT_STATUS_LSB +: STATUS_W] = status;
          out_data_nxt[OUT_POS_LSB +: POS_W]       = pos_ext[POS_W-1:0];
          out_data_nxt[OUT_POSTAL_LSB +: POSTAL_W] = res_postal;
          out_data_nxt[OUT_SENT_LSB]               = res_sent;
          out_data_nxt[OUT_COUNT_LSB +: COUNT_W]   = cnt_ext[COUNT_W-1:0];
          state_nxt     = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  // the row only moves in the cycle the result is committed
  logic go_gate;
  assign go_gate = commit;
  assign upd.go  = apply_go && go_gate;

  always_ff @(posedge clk) begin
    mode_r     <= mode_nxt;
    postal_r   <= postal_nxt;
    id_r       <= id_nxt;
    out_data_r <= out_data_nxt;
    if (!rst_n) begin
      state_r     <= S_IDLE;
      count_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
      if (go_gate) count_r <= count_nxt;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;

endmodule

@@ rtl/srt_checker.sv @@
// Port-level checker for the sorted record table and its bind
`include "sorted_record_table_unit_assert.svh"

module srt_checker #(
  parameter int TABLE_DEPTH = 32
) (
  input logic                     clk,
  input logic                     rst_n,
  input logic                     in_tvalid,
  input logic                     in_tready,
  input logic                     out_tvalid,
  input logic                     out_tready,
  input logic [srt_pkg::OUT_W-1:0] out_tdata
);
  import srt_pkg::*;

  logic [STATUS_W-1:0] st;
  logic [POS_W-1:0]    pos;
  logic [COUNT_W-1:0]  cnt;

  assign st  = out_tdata[OUT_STATUS_LSB +: STATUS_W];
  assign pos = out_tdata[OUT_POS_LSB +: POS_W];
  assign cnt = out_tdata[OUT_COUNT_LSB +: COUNT_W];

  `SRT_ASSERT_NEXT(a_out_hold, out_tvalid && !out_tready, out_tvalid && $stable(out_tdata), "result changed while stalled")
  `SRT_ASSERT_NEXT(a_one_at_a_time, in_tvalid && in_tready, !in_tready, "request taken while one is in progress")
  `SRT_ASSERT_NOW(a_count_bound, out_tvalid, int'(cnt) <= TABLE_DEPTH, "entry count beyond table depth")
  `SRT_ASSERT_NOW(a_fail_pos_zero, out_tvalid && (st == ST_FULL || st == ST_MISSING), pos == '0, "failed request reports a slot")

endmodule

bind sorted_record_table_unit srt_checker #(.TABLE_DEPTH(TABLE_DEPTH)) u_srt_checker (.*);

@@ tb/testbench.sv @@
`timescale 1ns / 100ps
// Self-checking testbench for the sorted record table unit: directed and random requests
module testbench;
  import srt_pkg::*;

  localparam int DEPTH = 32;
  localparam logic [ID_W-1:0]     ID_ALL     = '1;
  localparam logic [ID_W-1:0]     ID_DEC_MAX = 47'd99999999999999;
  localparam logic [POSTAL_W-1:0] POSTAL_ALL = '1;
  localparam logic [POSTAL_W-1:0] POSTAL_DEC = 20'd999999;

  typedef struct packed {
    status_t             status;
    logic [POS_W-1:0]    pos;
    logic [POSTAL_W-1:0] postal;
    logic                sent;
    logic [COUNT_W-1:0]  count;
  } reply_t;

  logic             clk        = 1'b0;
  logic             rst_n      = 1'b0;
  logic             in_tvalid  = 1'b0;
  logic             in_tready;
  logic [IN_W-1:0]  in_tdata   = '0;
  logic             out_tvalid;
  logic             out_tready = 1'b0;
  logic [OUT_W-1:0] out_tdata;

  logic   idle_en   = 1'b1;
  int     sink_hold = 0;
  int     errors    = 0;
  reply_t pending_replies[$];

  // shadow copy of the record table
  logic [POSTAL_W-1:0] shadow_postal [DEPTH];
  logic [ID_W-1:0]     shadow_id     [DEPTH];
  logic                shadow_sent   [DEPTH];
  int                  shadow_count = 0;

  sorted_record_table_unit dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .out_tvalid(out_tvalid),
    .out_tready(out_tready),
    .out_tdata (out_tdata)
  );

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  task automatic report_miss(input string what);
    errors++;
    if (errors <= 40) $display("%0t ns: %s", $time, what);
  endtask

  // applies one request to the shadow table and returns the reply it should give
  function automatic reply_t table_predict(input op_t op, input logic [POSTAL_W-1:0] pc,
                                           input logic [ID_W-1:0] id);
    reply_t r;
    int     hit;
    int     at;
    r = '0;
    r.status = ST_OK;
    hit = -1;
    for (int i = 0; i < shadow_count; i++)
      if (hit < 0 && shadow_id[i] == id) hit = i;
    if (op == OP_INSERT) begin
      if (hit >= 0) begin
        r.status = ST_DUP;
        r.pos = hit[POS_W-1:0];
      end else if (shadow_count >= DEPTH) begin
        r.status = ST_FULL;
      end else begin
        // first slot whose (postal, id) key is strictly greater
        at = 0;
        while (at < shadow_count && (shadow_postal[at] < pc ||
               (shadow_postal[at] == pc && shadow_id[at] <= id)))
          at++;
        for (int i = shadow_count; i > at; i--) begin
          shadow_postal[i] = shadow_postal[i-1];
          shadow_id[i]     = shadow_id[i-1];
          shadow_sent[i]   = shadow_sent[i-1];
        end
        shadow_postal[at] = pc;
        shadow_id[at]     = id;
        shadow_sent[at]   = 1'b0;
        shadow_count++;
        r.pos = at[POS_W-1:0];
      end
    end else if (hit < 0) begin
      r.status = ST_MISSING;
    end else begin
      r.pos = hit[POS_W-1:0];
      case (op)
        OP_DELETE: begin
          for (int i = hit; i + 1 < shadow_count; i++) begin
            shadow_postal[i] = shadow_postal[i+1];
            shadow_id[i]     = shadow_id[i+1];
            shadow_sent[i]   = shadow_sent[i+1];
          end
          shadow_count--;
        end
        OP_LOOKUP: begin
          r.postal = shadow_postal[hit];
          r.sent   = shadow_sent[hit];
        end
        default: begin
          shadow_sent[hit] = 1'b1;
          r.sent = 1'b1;
        end
      endcase
    end
    r.count = shadow_count[COUNT_W-1:0];
    return r;
  endfunction

  task automatic send_request(input op_t op, input logic [POSTAL_W-1:0] pc,
                              input logic [ID_W-1:0] id);
    logic [IN_W-1:0] word;
    word = '0;
    word[IN_MODE_LSB +: MODE_W]     = op;
    word[IN_POSTAL_LSB +: POSTAL_W] = pc;
    word[IN_ID_LSB +: ID_W]         = id;
    if (idle_en && $urandom_range(0, 4) == 0) begin
      in_tvalid <= 1'b0;
      repeat ($urandom_range(1, 10)) @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= word;
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    pending_replies.push_back(table_predict(op, pc, id));
  endtask

  // sink side: random stall bursts
  always @(posedge clk) begin
    if (sink_hold > 0) begin
      sink_hold  <= sink_hold - 1;
      out_tready <= 1'b0;
    end else if (idle_en && $urandom_range(0, 5) == 0) begin
      sink_hold  <= $urandom_range(0, 9);
      out_tready <= 1'b0;
    end else begin
      out_tready <= 1'b1;
    end
  end

  always @(posedge clk) begin : check_replies
    reply_t got;
    reply_t want;
    if (rst_n && out_tvalid && out_tready) begin
      got.status = status_t'(out_tdata[OUT_STATUS_LSB +: STATUS_W]);
      got.pos    = out_tdata[OUT_POS_LSB +: POS_W];
      got.postal = out_tdata[OUT_POSTAL_LSB +: POSTAL_W];
      got.sent   = out_tdata[OUT_SENT_LSB];
      got.count  = out_tdata[OUT_COUNT_LSB +: COUNT_W];
      if (pending_replies.size() == 0) begin
        report_miss("reply with no request outstanding");
      end else begin
        want = pending_replies.pop_front();
        if (got.status !== want.status)
          report_miss($sformatf("status got %0d want %0d", got.status, want.status));
        if (got.pos !== want.pos)
          report_miss($sformatf("position got %0d want %0d", got.pos, want.pos));
        if (got.postal !== want.postal)
          report_miss($sformatf("postal got %0d want %0d", got.postal, want.postal));
        if (got.sent !== want.sent)
          report_miss($sformatf("sent got %0b want %0b", got.sent, want.sent));
        if (got.count !== want.count)
          report_miss($sformatf("count got %0d want %0d", got.count, want.count));
      end
    end
  end

  function automatic logic [ID_W-1:0] pick_id(input int reuse_pct);
    logic [63:0] wide;
    wide = {$urandom, $urandom};
    if (shadow_count > 0 && $urandom_range(0, 99) < reuse_pct)
      return shadow_id[$urandom_range(0, shadow_count - 1)];
    case ($urandom_range(0, 3))
      0: return wide[ID_W-1:0];
      1: return ID_W'(wide[5:0]);
      2: return wide[0] ? ID_ALL : (wide[1] ? ID_DEC_MAX : '0);
      default: return ID_W'(wide[31:0]);
    endcase
  endfunction

  function automatic logic [POSTAL_W-1:0] pick_postal();
    logic [31:0] wide;
    wide = $urandom;
    case ($urandom_range(0, 4))
      0, 1: return POSTAL_W'(wide[2:0]);   // few values, so keys tie on postal
      2, 3: return wide[POSTAL_W-1:0];
      default: return wide[0] ? POSTAL_ALL : (wide[1] ? POSTAL_DEC : '0);
    endcase
  endfunction

  task automatic test_directed();
    send_request(OP_LOOKUP, '0, '0);
    send_request(OP_DELETE, POSTAL_ALL, ID_ALL);
    send_request(OP_MARK, '0, 47'd5);
    send_request(OP_INSERT, POSTAL_ALL, ID_ALL);
    send_request(OP_INSERT, '0, '0);
    send_request(OP_INSERT, 20'd500, 47'd10);
    send_request(OP_INSERT, 20'd500, 47'd9);    // postal tie, smaller id goes first
    send_request(OP_INSERT, 20'd500, 47'd11);
    send_request(OP_INSERT, 20'd7, 47'd10);     // duplicate id, other postal
    send_request(OP_INSERT, POSTAL_DEC, ID_DEC_MAX);
    send_request(OP_LOOKUP, '0, 47'd9);
    send_request(OP_MARK, '0, 47'd9);
    send_request(OP_LOOKUP, POSTAL_ALL, 47'd9);
    send_request(OP_MARK, '0, 47'd9);
    send_request(OP_MARK, '0, ID_ALL);
    send_request(OP_LOOKUP, '0, ID_ALL);
    send_request(OP_DELETE, '0, '0);            // first slot
    send_request(OP_DELETE, '0, ID_ALL);        // last slot
    send_request(OP_LOOKUP, '0, 47'd11);
    send_request(OP_DELETE, '0, 47'd10);        // middle slot
    send_request(OP_LOOKUP, '0, 47'd10);
    send_request(OP_INSERT, POSTAL_ALL, '0);
  endtask

  // alternates fill-heavy and drain-heavy stretches so the table runs full and empty
  task automatic test_random_mix(input int n_items, input bit allow_idle);
    bit  grow;
    int  roll;
    op_t op;
    grow = 1'b0;
    for (int k = 0; k < n_items; k++) begin
      if (k % 60 == 0) begin
        grow = !grow;
        idle_en = allow_idle && ($urandom_range(0, 3) != 0);
      end
      roll = $urandom_range(0, 99);
      if (grow)
        op = (roll < 75) ? OP_INSERT : (roll < 82) ? OP_DELETE :
             (roll < 92) ? OP_LOOKUP : OP_MARK;
      else
        op = (roll < 18) ? OP_INSERT : (roll < 70) ? OP_DELETE :
             (roll < 85) ? OP_LOOKUP : OP_MARK;
      send_request(op, pick_postal(), pick_id((op == OP_INSERT) ? 8 : 80));
    end
  endtask

  task automatic test_back_to_back();
    idle_en = 1'b0;
    test_random_mix(80, 1'b0);
  endtask

  initial begin
    int waited;
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
    test_directed();
    test_random_mix(1450, 1'b1);
    test_back_to_back();
    in_tvalid <= 1'b0;
    waited = 0;
    while (pending_replies.size() != 0 && waited < 2000) begin
      @(posedge clk);
      waited++;
    end
    repeat (10) @(posedge clk);
    if (pending_replies.size() != 0) report_miss("replies still outstanding at end");
    if (errors == 0) begin
      $display("sorted_record_table_unit: match");
    end else begin
      $display("sorted_record_table_unit: mismatch");
    end
    $finish;
  end

  initial begin
    #4_000_000;
    $display("sorted_record_table_unit: mismatch");
    $finish;
  end

endmodule

@@ sim.f @@
+incdir+rtl
rtl/srt_pkg.sv
rtl/srt_cell.sv
rtl/sorted_record_table_unit.sv
rtl/srt_checker.sv
tb/testbench.sv
